@@ hw/rtl/fwpr_pkg.sv @@
// Shared types, constants and codes for the prefix-reverse FIFO.
package fwpr_pkg;

   // Storage geometry; DEPTH must be a power of two (slot math wraps by truncation).
   localparam int DEPTH      = 128;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = 8;   // fixed by the count and k fields

   typedef enum logic [1:0] {
      REQ_ENQ = 2'd0,
      REQ_DEQ = 2'd1,
      REQ_REV = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_BIGK  = 2'd3
   } status_code_type;

   typedef enum logic [1:0] {
      WR_TAIL = 2'd0,
      WR_LO   = 2'd1,
      WR_HI   = 2'd2
   } wr_sel_type;

   typedef enum logic [1:0] {
      RD_HEAD = 2'd0,
      RD_LO   = 2'd1,
      RD_HI   = 2'd2
   } rd_sel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_REV_RA,
      S_REV_RB,
      S_REV_WA,
      S_REV_WB,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]        req_type;
      logic signed [31:0] value;
      logic [7:0]        k;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] data;
      logic [1:0]         status;
      logic [7:0]         count;
   } rsp_item_type;

   // Controller to datapath.
   typedef struct packed {
      logic       load_req;
      logic       mem_write;
      wr_sel_type wr_sel;
      logic       mem_read;
      rd_sel_type rd_sel;
      logic       push;
      logic       pop;
      logic       rev_init;
      logic       save_tmp;
      logic       rev_step;
      logic       rsp_load;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [1:0] op;
      logic       ok;
      logic       swaps_done;
   } stat_type;

endpackage

@@ hw/rtl/fwpr_datapath.sv @@
// Datapath: entry memory, head/count, reverse pointers and result register.
module fwpr_datapath
   import fwpr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cmd_type      cmd,
   input  req_item_type req_payload,
   output stat_type     stat,
   output rsp_item_type rsp_payload
);

   logic signed [DATA_WIDTH-1:0] store_mem [DEPTH];
   logic signed [DATA_WIDTH-1:0] rd_data_ff;
   logic signed [DATA_WIDTH-1:0] tmp_ff, tmp_in;

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  lo_ff, lo_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [CNT_W-1:0]  swaps_ff, swaps_in;

   req_item_type    req_ff, req_in;
   status_code_type code_ff, code_in;
   rsp_item_type    rsp_ff, rsp_in;

   logic [ADDR_W-1:0]            waddr, raddr;
   logic signed [DATA_WIDTH-1:0] wdata;
   logic [ADDR_W-1:0]            slot_lo, slot_hi, slot_tail;

   assign slot_lo   = head_ff + ADDR_W'(lo_ff);
   assign slot_hi   = head_ff + ADDR_W'(hi_ff);
   assign slot_tail = head_ff + ADDR_W'(count_ff);

   // Request decode against the count at accept time.
   always_comb begin
      code_in = code_ff;
      req_in  = req_ff;
      if (cmd.load_req) begin
         req_in  = req_payload;
         code_in = ST_OK;
         unique case (req_code_type'(req_payload.req_type))
            REQ_ENQ: if (count_ff == CNT_W'(DEPTH)) code_in = ST_FULL;
            REQ_DEQ: if (count_ff == '0)            code_in = ST_EMPTY;
            REQ_REV: if (req_payload.k > count_ff)  code_in = ST_BIGK;
            default: code_in = ST_OK;
         endcase
      end
   end

   assign stat.op         = req_ff.req_type;
   assign stat.ok         = (code_ff == ST_OK);
   assign stat.swaps_done = (swaps_ff == '0);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.push) count_in = count_ff + CNT_W'(1);
      if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
         head_in  = head_ff + ADDR_W'(1);
      end
   end

   // Swap pointers: lo walks up from the oldest entry, hi down from entry k-1.
   always_comb begin
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      swaps_in = swaps_ff;
      tmp_in   = tmp_ff;
      if (cmd.rev_init) begin
         lo_in    = '0;
         hi_in    = req_ff.k - CNT_W'(1);
         swaps_in = req_ff.k >> 1;
      end else if (cmd.rev_step) begin
         lo_in    = lo_ff + CNT_W'(1);
         hi_in    = hi_ff - CNT_W'(1);
         swaps_in = swaps_ff - CNT_W'(1);
      end
      if (cmd.save_tmp) tmp_in = rd_data_ff;
   end

   always_comb begin
      unique case (cmd.wr_sel)
         WR_LO: begin
            waddr = slot_lo;
            wdata = rd_data_ff;
         end
         WR_HI: begin
            waddr = slot_hi;
            wdata = tmp_ff;
         end
         default: begin
            waddr = slot_tail;
            wdata = DATA_WIDTH'(req_ff.value);
         end
      endcase
      unique case (cmd.rd_sel)
         RD_LO:   raddr = slot_lo;
         RD_HI:   raddr = slot_hi;
         default: raddr = head_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write) store_mem[waddr] <= wdata;
      if (cmd.mem_read)  rd_data_ff <= store_mem[raddr];
   end

   // Result: count is already post-update when this loads.
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         rsp_in.status = code_ff;
         rsp_in.count  = count_ff;
         rsp_in.data   = '0;
         if (req_code_type'(req_ff.req_type) == REQ_DEQ) begin
            if (code_ff == ST_OK) rsp_in.data = 32'(rd_data_ff);
            else                  rsp_in.data = -32'sd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      req_ff   <= req_in;
      code_ff  <= code_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      swaps_ff <= swaps_in;
      tmp_ff   <= tmp_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

@@ hw/rtl/fwpr_controller.sv @@
// Controller: request sequencing, swap loop and result handshake.
module fwpr_controller
   import fwpr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_EXEC;
         S_EXEC: begin
            if (req_code_type'(stat.op) == REQ_REV && stat.ok) state_in = S_REV_RA;
            else                                                 state_in = S_RESP;
         end
         S_REV_RA: state_in = stat.swaps_done ? S_RESP : S_REV_RB;
         S_REV_RB: state_in = S_REV_WA;
         S_REV_WA: state_in = S_REV_WB;
         S_REV_WB: state_in = S_REV_RA;
         S_RESP:   if (slot_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.wr_sel = WR_TAIL;
      cmd.rd_sel = RD_HEAD;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         S_EXEC: begin
            unique case (req_code_type'(stat.op))
               REQ_ENQ: begin
                  cmd.mem_write = stat.ok;
                  cmd.push      = stat.ok;
               end
               REQ_DEQ: begin
                  cmd.mem_read = stat.ok;
                  cmd.pop      = stat.ok;
               end
               REQ_REV: cmd.rev_init = stat.ok;
               default: cmd.rev_init = 1'b0;
            endcase
         end
         S_REV_RA: begin
            cmd.mem_read = !stat.swaps_done;
            cmd.rd_sel   = RD_LO;
         end
         S_REV_RB: begin
            cmd.mem_read = 1'b1;
            cmd.rd_sel   = RD_HI;
            cmd.save_tmp = 1'b1;
         end
         S_REV_WA: begin
            cmd.mem_write = 1'b1;
            cmd.wr_sel    = WR_LO;
         end
         S_REV_WB: begin
            cmd.mem_write = 1'b1;
            cmd.wr_sel    = WR_HI;
            cmd.rev_step  = 1'b1;
         end
         S_RESP:   cmd.rsp_load = slot_free;
         default:  req_ready = 1'b0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load)   rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/fifo_with_prefix_reverse_top.sv @@
// Top level of the prefix-reverse FIFO: controller plus datapath.
// A circular FIFO of DEPTH signed words (DEPTH a power of two) behind one
// request channel and one result channel, both valid/ready. Each request
// gives exactly one result: enqueue (refused with status FULL when full),
// dequeue (returns the oldest word; on empty, status EMPTY and data -1), or
// reverse of the oldest k entries in place (k above the count gives status
// BIGK and no change; k of 0 or 1 is a no-op). Request code 3 is ignored
// and answered with status OK. Every result carries the count after the
// request. Enqueue, dequeue, refused and ignored requests pass through an
// execute state and a result state; a reverse adds REV_RA, REV_RB, REV_WA
// and REV_WB for each of its floor(k/2) swaps, as the entry memory has one
// write and one registered read port, so each swap costs two reads and two
// writes issued in sequence. The result sits in an output register, so the
// next request is taken while a finished result still waits; only loading a
// new result waits for that register to drain. No clearing pass is needed
// after reset: only slots holding live entries are ever read.
module fifo_with_prefix_reverse_top
   import fwpr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_payload
);

   cmd_type  cmd;
   stat_type stat;

   fwpr_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fwpr_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ sim/tb_fifo_with_prefix_reverse_top.sv @@
// Self-checking testbench for the prefix-reverse FIFO: directed and random traffic against a shadow queue.
module tb_fifo_with_prefix_reverse_top;
   import fwpr_pkg::*;

   // Request code 3 has no package member; the block must ignore it.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // Receiver hold-off: long enough that the output register stays full and
   // the request side backs up while the sender keeps offering.
   localparam int unsigned HOLD_START = 1500;
   localparam int unsigned HOLD_LEN   = 600;

   localparam int unsigned RANDOM_ITEMS = 1300;
   localparam int unsigned SHOW_LIMIT   = 10;

   typedef enum {MIX_FILL, MIX_DRAIN, MIX_BLEND, MIX_NOISE} traffic_mode_type;
   typedef enum {RX_OPEN, RX_BUSY, RX_SLOW, RX_PULSE} rx_mode_type;

   // Shadow copy of the queue; predicts one response per accepted request
   // and checks responses in order against it.
   class fifo_shadow;
      logic [DATA_WIDTH-1:0] slots [DEPTH];
      int unsigned           head;
      int unsigned           held;
      rsp_item_type          expected_rsp [$];
      int unsigned           errors;

      function new();
         head   = 0;
         held   = 0;
         errors = 0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= SHOW_LIMIT)
            $display("%s", msg);
      endfunction

      function void note_request(req_item_type r);
         rsp_item_type          e;
         int unsigned           a;
         int unsigned           b;
         logic [DATA_WIDTH-1:0] t;
         e.data   = '0;
         e.status = ST_OK;
         case (r.req_type)
            REQ_ENQ: begin
               if (held >= DEPTH) begin
                  e.status = ST_FULL;
               end else begin
                  slots[(head + held) % DEPTH] = r.value;
                  held++;
               end
            end
            REQ_DEQ: begin
               if (held == 0) begin
                  e.status = ST_EMPTY;
                  e.data   = -32'sd1;
               end else begin
                  e.data = slots[head];
                  head   = (head + 1) % DEPTH;
                  held--;
               end
            end
            REQ_REV: begin
               if (r.k > held) begin
                  e.status = ST_BIGK;
               end else begin
                  // swap pairs from both ends of the oldest k entries
                  for (int i = 0; i < r.k / 2; i++) begin
                     a        = (head + i) % DEPTH;
                     b        = (head + r.k - 1 - i) % DEPTH;
                     t        = slots[a];
                     slots[a] = slots[b];
                     slots[b] = t;
                  end
               end
            end
            default: ;  // unused code: no state change
         endcase
         e.count = held[7:0];
         expected_rsp.push_back(e);
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type e;
         if (expected_rsp.size() == 0) begin
            flag($sformatf("unexpected response: data %0d status %0d count %0d",
                           got.data, got.status, got.count));
            return;
         end
         e = expected_rsp.pop_front();
         if (got.data !== e.data || got.status !== e.status || got.count !== e.count)
            flag($sformatf({"response mismatch: expected data %0d status %0d count %0d,",
                            " got data %0d status %0d count %0d"},
                           e.data, e.status, e.count, got.data, got.status, got.count));
      endfunction

      function int unsigned pending();
         return expected_rsp.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_payload;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_payload;

   fifo_shadow sb = new();

   // Sender burst bookkeeping, shared by every call of issue().
   int unsigned burst_left = 0;

   fifo_with_prefix_reverse_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic req_item_type make_req(logic [1:0] code, logic [31:0] word,
                                             logic [7:0] kk);
      req_item_type r;
      r.req_type = code;
      r.value    = word;
      r.k        = kk;
      return r;
   endfunction

   // Mostly random words, with the sign extremes, zero and all-ones mixed in.
   function automatic logic [31:0] pick_word();
      if ($urandom_range(0, 99) < 12) begin
         case ($urandom_range(0, 3))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
         endcase
      end
      return $urandom;
   endfunction

   // Reverse length: mostly legal and short, sometimes the whole queue,
   // now and then one past the count.
   function automatic logic [7:0] pick_k(int unsigned held);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 5)
         return 8'(held + 1);
      if (roll < 60)
         return 8'($urandom_range(0, (held < 8) ? held : 8));
      if (roll < 85)
         return 8'($urandom_range(0, held));
      return 8'(held);
   endfunction

   function automatic req_item_type make_request(traffic_mode_type mode);
      req_item_type r;
      int unsigned  roll;
      roll       = $urandom_range(0, 99);
      r.value    = pick_word();
      r.k        = 8'($urandom);  // junk for enqueue/dequeue, must be ignored
      r.req_type = REQ_ENQ;
      case (mode)
         MIX_FILL: begin
            if (roll < 85)      r.req_type = REQ_ENQ;
            else if (roll < 95) r.req_type = REQ_REV;
            else                r.req_type = REQ_DEQ;
         end
         MIX_DRAIN: begin
            if (roll < 85)      r.req_type = REQ_DEQ;
            else if (roll < 95) r.req_type = REQ_REV;
            else                r.req_type = REQ_ENQ;
         end
         MIX_BLEND: begin
            if (roll < 40)      r.req_type = REQ_ENQ;
            else if (roll < 75) r.req_type = REQ_DEQ;
            else                r.req_type = REQ_REV;
         end
         default: begin
            // noise: any code, any k
            r.req_type = 2'($urandom_range(0, 3));
            return r;
         end
      endcase
      if (r.req_type == REQ_REV)
         r.k = pick_k(sb.held);
      return r;
   endfunction

   // Offer one request and hold it until the block takes it. Gaps fall only
   // between bursts, so valid is never dropped and raised in one step.
   task automatic issue(input req_item_type item);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
   endtask

   // Receiver: ready follows a randomly chosen pattern per segment, plus one
   // long hold-off counted here in cycles.
   initial begin : response_side
      int unsigned cyc;
      int unsigned seg_left;
      rx_mode_type rmode;
      logic        ready_next;
      rsp_ready <= 1'b0;
      cyc      = 0;
      seg_left = 0;
      rmode    = RX_OPEN;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_response(rsp_payload);
         cyc++;
         if (seg_left == 0) begin
            rmode    = rx_mode_type'($urandom_range(0, 3));
            seg_left = $urandom_range(20, 120);
         end
         seg_left--;
         case (rmode)
            RX_OPEN:  ready_next = 1'b1;
            RX_BUSY:  ready_next = ($urandom_range(0, 3) != 0);
            RX_SLOW:  ready_next = ($urandom_range(0, 3) == 0);
            default:  ready_next = cyc[2];
         endcase
         if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
            ready_next = 1'b0;
         rsp_ready <= ready_next;
      end
   end

   // Stimulus: reset, directed corner requests, then random phases.
   initial begin : request_side
      req_item_type     directed [$];
      traffic_mode_type mode;
      int unsigned      len;
      int unsigned      total;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty queue corners
      directed.push_back(make_req(REQ_DEQ, 32'h1234_5678, 8'd0));
      directed.push_back(make_req(REQ_REV, 32'h0, 8'd0));
      directed.push_back(make_req(REQ_REV, 32'h0, 8'd1));
      directed.push_back(make_req(REQ_REV, 32'hffff_ffff, 8'd255));
      directed.push_back(make_req(REQ_UNUSED, 32'hdead_beef, 8'd3));
      // word extremes and alternating bit patterns
      directed.push_back(make_req(REQ_ENQ, 32'h7fff_ffff, 8'd255));
      directed.push_back(make_req(REQ_ENQ, 32'h8000_0000, 8'd0));
      directed.push_back(make_req(REQ_ENQ, 32'h0000_0000, 8'd128));
      directed.push_back(make_req(REQ_ENQ, 32'hffff_ffff, 8'd1));
      directed.push_back(make_req(REQ_ENQ, 32'h5555_5555, 8'd85));
      directed.push_back(make_req(REQ_ENQ, 32'haaaa_aaaa, 8'd170));
      // trivial, oversized, whole, odd and even reverses
      directed.push_back(make_req(REQ_REV, 32'h0, 8'd1));
      directed.push_back(make_req(REQ_REV, 32'h0, 8'd0));
      directed.push_back(make_req(REQ_REV, 32'h0, 8'd7));
      directed.push_back(make_req(REQ_REV, 32'h0, 8'd6));
      directed.push_back(make_req(REQ_REV, 32'h0, 8'd5));
      directed.push_back(make_req(REQ_REV, 32'h0, 8'd2));
      directed.push_back(make_req(REQ_UNUSED, 32'hffff_ffff, 8'd255));
      // drain through to an empty dequeue
      repeat (6) directed.push_back(make_req(REQ_DEQ, 32'h0, 8'd0));
      directed.push_back(make_req(REQ_DEQ, 32'hffff_ffff, 8'd255));

      foreach (directed[i])
         issue(directed[i]);

      // First phase is a long fill so the full refusal and k = DEPTH get hit.
      total = 0;
      mode  = MIX_FILL;
      len   = 200;
      while (total < RANDOM_ITEMS) begin
         repeat (len) begin
            issue(make_request(mode));
            total++;
         end
         mode = traffic_mode_type'($urandom_range(0, 3));
         len  = $urandom_range(30, 180);
      end
      req_valid <= 1'b0;

      // Drain, then keep clocking so anything stray can show up.
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (sb.errors == 0) begin
         $display("fifo_with_prefix_reverse_top verification clean");
      end else begin
         $display("fifo_with_prefix_reverse_top verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (all long reverses, slow receiver).
   initial begin
      #4000000;
      $display("fifo_with_prefix_reverse_top verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/fwpr_pkg.sv
hw/rtl/fwpr_datapath.sv
hw/rtl/fwpr_controller.sv
hw/rtl/fifo_with_prefix_reverse_top.sv
sim/tb_fifo_with_prefix_reverse_top.sv
